// ----- sv/dct8_pkg.sv -----
// Shared types and constants for the 8-point fixed-point DCT / IDCT.
// Used by the forward and inverse datapaths, the top level and the port checker.
package dct8_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int OUT_BITS    = 20;
  // datapath register stages ahead of the output register
  localparam int NSTAGE      = 4;
  // width of the signed rotation coefficients
  localparam int CW          = 12;

  // forward rotation constants (10-bit fraction)
  localparam int FWD_C1   = 1004;
  localparam int FWD_S1   = 200;
  localparam int FWD_C3   = 851;
  localparam int FWD_S3   = 569;
  localparam int FWD_R2C6 = 554;
  localparam int FWD_R2S6 = 1337;
  // sqrt(2) as 181/128
  localparam int R2       = 181;
  // inverse rotation constants (8/9-bit fraction)
  localparam int INV_C1   = 251;
  localparam int INV_S1   = 50;
  localparam int INV_C3   = 213;
  localparam int INV_S3   = 142;
  localparam int INV_R2C6 = 277;
  localparam int INV_R2S6 = 669;

  // shift amounts
  localparam int FWD_SH     = 10;
  localparam int R2_SH      = 17;
  localparam int INV_PRE_DC = 9;   // x512 on elements 0 and 4
  localparam int INV_PRE_OD = 7;   // x128 on elements 1 and 7
  localparam int INV_MID_SH = 6;
  localparam int INV_SH     = 10;

  typedef logic signed [CW-1:0] coef_t;

  localparam coef_t K_R2     = coef_t'(R2);
  localparam coef_t KF_C1    = coef_t'(FWD_C1);
  localparam coef_t KF_A2    = coef_t'(-FWD_S1 - FWD_C1);
  localparam coef_t KF_A1    = coef_t'(FWD_S1 - FWD_C1);
  localparam coef_t KF_C3    = coef_t'(FWD_C3);
  localparam coef_t KF_A3    = coef_t'(-FWD_S3 - FWD_C3);
  localparam coef_t KF_A0    = coef_t'(FWD_S3 - FWD_C3);
  localparam coef_t KF_R2C6  = coef_t'(FWD_R2C6);
  localparam coef_t KF_A7    = coef_t'(-FWD_R2S6 - FWD_R2C6);
  localparam coef_t KF_A8    = coef_t'(FWD_R2S6 - FWD_R2C6);
  localparam coef_t KI_R2C6  = coef_t'(INV_R2C6);
  localparam coef_t KI_A6    = coef_t'(-INV_R2C6 - INV_R2S6);
  localparam coef_t KI_A2    = coef_t'(-INV_R2C6 + INV_R2S6);
  localparam coef_t KI_C3    = coef_t'(INV_C3);
  localparam coef_t KI_A5    = coef_t'(-INV_C3 - INV_S3);
  localparam coef_t KI_A4    = coef_t'(-INV_C3 + INV_S3);
  localparam coef_t KI_C1    = coef_t'(INV_C1);
  localparam coef_t KI_A1    = coef_t'(-INV_C1 - INV_S1);
  localparam coef_t KI_A8    = coef_t'(-INV_C1 + INV_S1);

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] in_0;
    logic signed [SAMPLE_BITS-1:0] in_1;
    logic signed [SAMPLE_BITS-1:0] in_2;
    logic signed [SAMPLE_BITS-1:0] in_3;
    logic signed [SAMPLE_BITS-1:0] in_4;
    logic signed [SAMPLE_BITS-1:0] in_5;
    logic signed [SAMPLE_BITS-1:0] in_6;
    logic signed [SAMPLE_BITS-1:0] in_7;
  } in_item_t;

  typedef struct packed {
    logic signed [OUT_BITS-1:0] out_0;
    logic signed [OUT_BITS-1:0] out_1;
    logic signed [OUT_BITS-1:0] out_2;
    logic signed [OUT_BITS-1:0] out_3;
    logic signed [OUT_BITS-1:0] out_4;
    logic signed [OUT_BITS-1:0] out_5;
    logic signed [OUT_BITS-1:0] out_6;
    logic signed [OUT_BITS-1:0] out_7;
  } out_item_t;

endpackage

// ----- sv/dct8_fwd.sv -----
// Forward 8-point DCT datapath: four register stages, advanced by per-stage enables.
// Depends on dct8_pkg for the item types and rotation constants.
module dct8_fwd (
  input  logic                          clk,
  input  logic [dct8_pkg::NSTAGE-1:0]   stage_en,
  input  dct8_pkg::in_item_t            din,
  output dct8_pkg::out_item_t           dout
);

  localparam int W0 = dct8_pkg::SAMPLE_BITS;
  localparam int W1 = W0 + 1;
  localparam int W2 = W0 + 2;
  localparam int W3 = W0 + 3;
  localparam int WP = W3 + dct8_pkg::CW;
  localparam int WS = WP + 2;
  localparam int WT = WS + 1;
  localparam int WR = WS + dct8_pkg::CW;
  localparam int WO = dct8_pkg::OUT_BITS;
  localparam logic signed [WT-1:0] HALF_F = WT'(2 ** (dct8_pkg::FWD_SH - 1));
  localparam logic signed [WR-1:0] HALF_R = WR'(2 ** (dct8_pkg::R2_SH - 1));

  // stage 1: two butterfly levels
  logic signed [W1-1:0] b5, b6, b7, b8;
  logic signed [W1-1:0] t0_nxt, t1_nxt, t2_nxt, t3_nxt;
  logic signed [W1-1:0] t0_r, t1_r, t2_r, t3_r;
  logic signed [W2-1:0] e4_nxt, e5_nxt, e7_nxt, e8_nxt;
  logic signed [W2-1:0] e4_r, e5_r, e7_r, e8_r;

  always_comb begin
    b8     = W1'(din.in_0) + W1'(din.in_7);
    t0_nxt = W1'(din.in_0) - W1'(din.in_7);
    b7     = W1'(din.in_1) + W1'(din.in_6);
    t1_nxt = W1'(din.in_1) - W1'(din.in_6);
    b6     = W1'(din.in_2) + W1'(din.in_5);
    t2_nxt = W1'(din.in_2) - W1'(din.in_5);
    b5     = W1'(din.in_3) + W1'(din.in_4);
    t3_nxt = W1'(din.in_3) - W1'(din.in_4);
    e4_nxt = W2'(b8) + W2'(b5);
    e8_nxt = W2'(b8) - W2'(b5);
    e5_nxt = W2'(b7) + W2'(b6);
    e7_nxt = W2'(b7) - W2'(b6);
  end

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      t0_r <= t0_nxt;
      t1_r <= t1_nxt;
      t2_r <= t2_nxt;
      t3_r <= t3_nxt;
      e4_r <= e4_nxt;
      e5_r <= e5_nxt;
      e7_r <= e7_nxt;
      e8_r <= e8_nxt;
    end
  end

  // stage 2: rotation products, DC/Nyquist butterfly
  logic signed [W2-1:0] s12, s03;
  logic signed [W3-1:0] s78;
  logic signed [WP-1:0] p6a_nxt, p2_nxt, p1_nxt, p6b_nxt, p3_nxt, p0_nxt;
  logic signed [WP-1:0] p5_nxt, p7_nxt, p8_nxt;
  logic signed [WP-1:0] p6a_r, p2_r, p1_r, p6b_r, p3_r, p0_r, p5_r, p7_r, p8_r;
  logic signed [W3-1:0] g6_nxt, g4_nxt, g6_r, g4_r;

  always_comb begin
    s12     = W2'(t1_r) + W2'(t2_r);
    s03     = W2'(t0_r) + W2'(t3_r);
    s78     = W3'(e7_r) + W3'(e8_r);
    p6a_nxt = WP'(dct8_pkg::KF_C1)   * WP'(s12);
    p2_nxt  = WP'(dct8_pkg::KF_A2)   * WP'(t2_r);
    p1_nxt  = WP'(dct8_pkg::KF_A1)   * WP'(t1_r);
    p6b_nxt = WP'(dct8_pkg::KF_C3)   * WP'(s03);
    p3_nxt  = WP'(dct8_pkg::KF_A3)   * WP'(t3_r);
    p0_nxt  = WP'(dct8_pkg::KF_A0)   * WP'(t0_r);
    p5_nxt  = WP'(dct8_pkg::KF_R2C6) * WP'(s78);
    p7_nxt  = WP'(dct8_pkg::KF_A7)   * WP'(e7_r);
    p8_nxt  = WP'(dct8_pkg::KF_A8)   * WP'(e8_r);
    g6_nxt  = W3'(e4_r) + W3'(e5_r);
    g4_nxt  = W3'(e4_r) - W3'(e5_r);
  end

  always_ff @(posedge clk) begin
    if (stage_en[1]) begin
      p6a_r <= p6a_nxt;
      p2_r  <= p2_nxt;
      p1_r  <= p1_nxt;
      p6b_r <= p6b_nxt;
      p3_r  <= p3_nxt;
      p0_r  <= p0_nxt;
      p5_r  <= p5_nxt;
      p7_r  <= p7_nxt;
      p8_r  <= p8_nxt;
      g6_r  <= g6_nxt;
      g4_r  <= g4_nxt;
    end
  end

  // stage 3: finish rotations, odd butterfly
  logic signed [WS-1:0] r0, r1, r2, r3;
  logic signed [WS-1:0] h0_nxt, h2_nxt, h3_nxt, h5_nxt, h7_nxt, h8_nxt;
  logic signed [WS-1:0] h0_r, h2_r, h3_r, h5_r, h7_r, h8_r;
  logic signed [W3-1:0] k6_r, k4_r;

  always_comb begin
    r2     = WS'(p2_r) + WS'(p6a_r);
    r1     = WS'(p1_r) + WS'(p6a_r);
    r3     = WS'(p3_r) + WS'(p6b_r);
    r0     = WS'(p0_r) + WS'(p6b_r);
    h7_nxt = WS'(p7_r) + WS'(p5_r);
    h8_nxt = WS'(p8_r) + WS'(p5_r);
    h5_nxt = r0 + r2;
    h0_nxt = r0 - r2;
    h2_nxt = r3 + r1;
    h3_nxt = r3 - r1;
  end

  always_ff @(posedge clk) begin
    if (stage_en[2]) begin
      h0_r <= h0_nxt;
      h2_r <= h2_nxt;
      h3_r <= h3_nxt;
      h5_r <= h5_nxt;
      h7_r <= h7_nxt;
      h8_r <= h8_nxt;
      k6_r <= g6_r;
      k4_r <= g4_r;
    end
  end

  // stage 4: sqrt(2) scaling of the middle odd terms, rounding
  logic signed [WR-1:0] m3, m0;
  logic signed [WT-1:0] o1, o2, o6, o7;
  dct8_pkg::out_item_t  res_nxt, res_r;

  always_comb begin
    m3 = WR'(dct8_pkg::K_R2) * WR'(h3_r) + HALF_R;
    m0 = WR'(dct8_pkg::K_R2) * WR'(h0_r) + HALF_R;
    o2 = WT'(h8_r) + HALF_F;
    o6 = WT'(h7_r) + HALF_F;
    o7 = WT'(h2_r) - WT'(h5_r) + HALF_F;
    o1 = WT'(h2_r) + WT'(h5_r) + HALF_F;
    res_nxt.out_0 = WO'(k6_r);
    res_nxt.out_4 = WO'(k4_r);
    res_nxt.out_2 = WO'(o2 >>> dct8_pkg::FWD_SH);
    res_nxt.out_6 = WO'(o6 >>> dct8_pkg::FWD_SH);
    res_nxt.out_7 = WO'(o7 >>> dct8_pkg::FWD_SH);
    res_nxt.out_1 = WO'(o1 >>> dct8_pkg::FWD_SH);
    res_nxt.out_3 = WO'(m3 >>> dct8_pkg::R2_SH);
    res_nxt.out_5 = WO'(m0 >>> dct8_pkg::R2_SH);
  end

  always_ff @(posedge clk) begin
    if (stage_en[3]) begin
      res_r <= res_nxt;
    end
  end

  assign dout = res_r;

endmodule

// ----- sv/dct8_inv.sv -----
// Inverse 8-point DCT datapath: four register stages, advanced by per-stage enables.
// Depends on dct8_pkg for the item types and rotation constants.
module dct8_inv (
  input  logic                          clk,
  input  logic [dct8_pkg::NSTAGE-1:0]   stage_en,
  input  dct8_pkg::in_item_t            din,
  output dct8_pkg::out_item_t           dout
);

  localparam int W0 = dct8_pkg::SAMPLE_BITS;
  localparam int W1 = W0 + 1;
  localparam int WA = W0 + 10;
  localparam int WQ = W1 + dct8_pkg::CW;
  localparam int WB = W0 + 16;
  localparam int WR = WA + dct8_pkg::CW;
  localparam int WF = WR + 2;
  localparam int WO = dct8_pkg::OUT_BITS;
  localparam logic signed [WB-1:0] HALF_I = WB'(2 ** (dct8_pkg::INV_SH - 1));

  // stage 1: input scaling, first butterflies
  logic signed [WA-1:0] a0, a1, a4, a7;
  logic signed [WA-1:0] x0_nxt, x1_nxt, x3_nxt, x5_nxt, x7_nxt, x8_nxt;
  logic signed [WA-1:0] x0_r, x1_r, x3_r, x5_r, x7_r, x8_r;
  logic signed [W0-1:0] x2_r, x6_r;
  logic signed [W1-1:0] s26_nxt, s26_r;

  always_comb begin
    a0      = WA'(din.in_0) <<< dct8_pkg::INV_PRE_DC;
    a4      = WA'(din.in_4) <<< dct8_pkg::INV_PRE_DC;
    a1      = WA'(din.in_1) <<< dct8_pkg::INV_PRE_OD;
    a7      = WA'(din.in_7) <<< dct8_pkg::INV_PRE_OD;
    x3_nxt  = WA'(dct8_pkg::K_R2) * WA'(din.in_3);
    x5_nxt  = WA'(dct8_pkg::K_R2) * WA'(din.in_5);
    x8_nxt  = a7 + a1;
    x1_nxt  = a1 - a7;
    x7_nxt  = a0 + a4;
    x0_nxt  = a0 - a4;
    s26_nxt = W1'(din.in_2) + W1'(din.in_6);
  end

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      x0_r  <= x0_nxt;
      x1_r  <= x1_nxt;
      x3_r  <= x3_nxt;
      x5_r  <= x5_nxt;
      x7_r  <= x7_nxt;
      x8_r  <= x8_nxt;
      x2_r  <= din.in_2;
      x6_r  <= din.in_6;
      s26_r <= s26_nxt;
    end
  end

  // stage 2: odd butterflies, even rotation products
  logic signed [WA-1:0] y1_nxt, y4_nxt, y5_nxt, y8_nxt, s45_nxt, s18_nxt;
  logic signed [WA-1:0] y0_r, y1_r, y4_r, y5_r, y7_r, y8_r, s45_r, s18_r;
  logic signed [WQ-1:0] q2_nxt, q3_nxt, q6_nxt, q2_r, q3_r, q6_r;

  always_comb begin
    y4_nxt  = x1_r + x5_r;
    y1_nxt  = x1_r - x5_r;
    y5_nxt  = x3_r + x8_r;
    y8_nxt  = x8_r - x3_r;
    s45_nxt = y4_nxt + y5_nxt;
    s18_nxt = y1_nxt + y8_nxt;
    q3_nxt  = WQ'(dct8_pkg::KI_R2C6) * WQ'(s26_r);
    q6_nxt  = WQ'(dct8_pkg::KI_A6)   * WQ'(x6_r);
    q2_nxt  = WQ'(dct8_pkg::KI_A2)   * WQ'(x2_r);
  end

  always_ff @(posedge clk) begin
    if (stage_en[1]) begin
      y0_r  <= x0_r;
      y7_r  <= x7_r;
      y1_r  <= y1_nxt;
      y4_r  <= y4_nxt;
      y5_r  <= y5_nxt;
      y8_r  <= y8_nxt;
      s45_r <= s45_nxt;
      s18_r <= s18_nxt;
      q2_r  <= q2_nxt;
      q3_r  <= q3_nxt;
      q6_r  <= q6_nxt;
    end
  end

  // stage 3: odd rotation products, even butterflies with the final rounding half
  logic signed [WR-1:0] r6_nxt, r5_nxt, r4_nxt, r6b_nxt, r1_nxt, r8_nxt;
  logic signed [WR-1:0] r6_r, r5_r, r4_r, r6b_r, r1_r, r8_r;
  logic signed [WB-1:0] e2, e6;
  logic signed [WB-1:0] z0_nxt, z2_nxt, z3_nxt, z7_nxt, z0_r, z2_r, z3_r, z7_r;

  always_comb begin
    r6_nxt  = WR'(dct8_pkg::KI_C3) * WR'(s45_r);
    r5_nxt  = WR'(dct8_pkg::KI_A5) * WR'(y5_r);
    r4_nxt  = WR'(dct8_pkg::KI_A4) * WR'(y4_r);
    r6b_nxt = WR'(dct8_pkg::KI_C1) * WR'(s18_r);
    r1_nxt  = WR'(dct8_pkg::KI_A1) * WR'(y1_r);
    r8_nxt  = WR'(dct8_pkg::KI_A8) * WR'(y8_r);
    e6      = WB'(q3_r) + WB'(q6_r);
    e2      = WB'(q3_r) + WB'(q2_r);
    z3_nxt  = WB'(y7_r) + e2 + HALF_I;
    z7_nxt  = WB'(y7_r) - e2 + HALF_I;
    z2_nxt  = WB'(y0_r) + e6 + HALF_I;
    z0_nxt  = WB'(y0_r) - e6 + HALF_I;
  end

  always_ff @(posedge clk) begin
    if (stage_en[2]) begin
      r6_r  <= r6_nxt;
      r5_r  <= r5_nxt;
      r4_r  <= r4_nxt;
      r6b_r <= r6b_nxt;
      r1_r  <= r1_nxt;
      r8_r  <= r8_nxt;
      z0_r  <= z0_nxt;
      z2_r  <= z2_nxt;
      z3_r  <= z3_nxt;
      z7_r  <= z7_nxt;
    end
  end

  // stage 4: floor shift of the odd terms, output butterfly, final shift
  logic signed [WF-1:0] u1, u4, u5, u8;
  logic signed [WF-1:0] o0, o1, o2, o3, o4, o5, o6, o7;
  dct8_pkg::out_item_t  res_nxt, res_r;

  always_comb begin
    u5 = (WF'(r6_r)  + WF'(r5_r)) >>> dct8_pkg::INV_MID_SH;
    u4 = (WF'(r6_r)  + WF'(r4_r)) >>> dct8_pkg::INV_MID_SH;
    u1 = (WF'(r6b_r) + WF'(r1_r)) >>> dct8_pkg::INV_MID_SH;
    u8 = (WF'(r6b_r) + WF'(r8_r)) >>> dct8_pkg::INV_MID_SH;
    o0 = (WF'(z3_r) + u4) >>> dct8_pkg::INV_SH;
    o1 = (WF'(z2_r) + u8) >>> dct8_pkg::INV_SH;
    o2 = (WF'(z0_r) + u1) >>> dct8_pkg::INV_SH;
    o3 = (WF'(z7_r) + u5) >>> dct8_pkg::INV_SH;
    o4 = (WF'(z7_r) - u5) >>> dct8_pkg::INV_SH;
    o5 = (WF'(z0_r) - u1) >>> dct8_pkg::INV_SH;
    o6 = (WF'(z2_r) - u8) >>> dct8_pkg::INV_SH;
    o7 = (WF'(z3_r) - u4) >>> dct8_pkg::INV_SH;
    res_nxt.out_0 = WO'(o0);
    res_nxt.out_1 = WO'(o1);
    res_nxt.out_2 = WO'(o2);
    res_nxt.out_3 = WO'(o3);
    res_nxt.out_4 = WO'(o4);
    res_nxt.out_5 = WO'(o5);
    res_nxt.out_6 = WO'(o6);
    res_nxt.out_7 = WO'(o7);
  end

  always_ff @(posedge clk) begin
    if (stage_en[3]) begin
      res_r <= res_nxt;
    end
  end

  assign dout = res_r;

endmodule

// ----- sv/dct8_idct8_fixed_point.sv -----
// Top level of the 8-point fixed-point DCT / IDCT with valid/ready channels.
// Depends on dct8_pkg, dct8_fwd and dct8_inv.

// One eight-element vector is accepted per clock when the output side keeps up, and its
// result reaches the output through four datapath register stages (at most one multiplier
// level per stage) plus the output register. Each stage moves when it is empty or the stage
// after it moves, so bubbles close up under backpressure and the input keeps taking vectors
// while a finished result waits. The mode register is sampled when a vector is accepted and
// travels with it, so a new mode applies to vectors accepted after the write.
module dct8_idct8_fixed_point (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  dct8_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output dct8_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic                cfg_wdata
);

  localparam int NS = dct8_pkg::NSTAGE;

  logic                inv_mode_r;
  logic [NS-1:0]       vld_r, vld_nxt;
  logic [NS-1:0]       mode_r, mode_nxt;
  logic [NS-1:0]       stage_en;
  logic                out_en;
  logic                out_valid_r;
  dct8_pkg::out_item_t out_data_r;
  dct8_pkg::out_item_t fwd_res, inv_res;

  // stage enables ripple back from the output register
  always_comb begin
    out_en = !out_valid_r || out_ready;
    stage_en[NS-1] = !vld_r[NS-1] || out_en;
    for (int k = NS - 2; k >= 0; k--) begin
      stage_en[k] = !vld_r[k] || stage_en[k+1];
    end
  end

  always_comb begin
    vld_nxt  = vld_r;
    mode_nxt = mode_r;
    if (stage_en[0]) begin
      vld_nxt[0]  = in_valid;
      mode_nxt[0] = inv_mode_r;
    end
    for (int k = 1; k < NS; k++) begin
      if (stage_en[k]) begin
        vld_nxt[k]  = vld_r[k-1];
        mode_nxt[k] = mode_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
      inv_mode_r  <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
      if (out_en) begin
        out_valid_r <= vld_r[NS-1];
      end
      if (cfg_we) begin
        inv_mode_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    mode_r <= mode_nxt;
    if (out_en) begin
      out_data_r <= mode_r[NS-1] ? inv_res : fwd_res;
    end
  end

  dct8_fwd u_fwd (
    .clk      (clk),
    .stage_en (stage_en),
    .din      (in_data),
    .dout     (fwd_res)
  );

  dct8_inv u_inv (
    .clk      (clk),
    .stage_en (stage_en),
    .din      (in_data),
    .dout     (inv_res)
  );

  assign in_ready  = rst_n && stage_en[0];
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- sv/dct8_chk.sv -----
// Port-level checker for dct8_idct8_fixed_point, attached with a bind.
// Depends on dct8_pkg for the item types.
module dct8_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input dct8_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input dct8_pkg::out_item_t out_data
);

  logic       flow_ok;
  logic [4:0] rst_hist_r;
  logic [3:0] rdy_hist_r;

  always_ff @(posedge clk) begin
    rst_hist_r <= {rst_hist_r[3:0], rst_n};
    rdy_hist_r <= {rdy_hist_r[2:0], out_ready};
  end

  // uninterrupted flow (reset released, out_ready high) behind the current edge
  assign flow_ok = (&rst_hist_r) && (&rdy_hist_r);

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid || out_ready |-> in_ready)
    else $error("input stalled with output side free");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    flow_ok && $past(in_valid && in_ready, 5) |-> out_valid)
    else $error("transaction did not arrive after five cycles of flow");

  a_zero_maps_zero: assert property (@(posedge clk) disable iff (!rst_n)
    flow_ok && $past(in_valid && in_ready && (in_data == '0), 5) |-> out_data == '0)
    else $error("all-zero vector gave nonzero result");

endmodule

bind dct8_idct8_fixed_point dct8_chk u_dct8_chk (.*);

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps
// Self-checking bench for dct8_idct8_fixed_point: forward and inverse 8-point transforms.
// Depends on dct8_pkg (port types) and the DUT top; expected vectors come from a local model.

module tb;

  localparam int SB = dct8_pkg::SAMPLE_BITS;
  localparam int OB = dct8_pkg::OUT_BITS;
  localparam int SETTLE_CYCLES = 12;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int RAND_ITEMS = 1750;
  localparam int RAND_PHASES = 8;

  localparam logic signed [SB-1:0] SMAX = {1'b0, {(SB-1){1'b1}}};
  localparam logic signed [SB-1:0] SMIN = {1'b1, {(SB-1){1'b0}}};

  localparam bit MODE_FWD = 1'b0;
  localparam bit MODE_INV = 1'b1;

  // forward rotations, 10-bit fraction
  localparam longint F_C1 = 1004, F_S1 = 200, F_C3 = 851, F_S3 = 569;
  localparam longint F_R2C6 = 554, F_R2S6 = 1337;
  // inverse rotations, 8/9-bit fraction
  localparam longint I_C1 = 251, I_S1 = 50, I_C3 = 213, I_S3 = 142;
  localparam longint I_R2C6 = 277, I_R2S6 = 669;
  localparam longint SQRT2_Q7 = 181;

  typedef struct {
    bit                  inv;
    bit                  chk;
    dct8_pkg::in_item_t  stim;
    dct8_pkg::out_item_t res;
  } dir_row_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  dct8_pkg::in_item_t  in_data;
  logic                out_valid;
  logic                out_ready;
  dct8_pkg::out_item_t out_data;
  logic                cfg_we;
  logic                cfg_wdata;

  dct8_pkg::out_item_t xform_due[$];
  bit                  mode_now;
  int unsigned         calm_left;
  int unsigned         fail_cnt;
  int unsigned         cycle_cnt;

  dct8_idct8_fixed_point i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Directed vectors. Expected values are given only where obvious:
  // flat inputs in forward mode, a lone DC term in inverse mode.
  dir_row_t dir_rows [22] = '{
    '{MODE_FWD, 1'b1, '{default: 0}, '{default: 0}},
    '{MODE_FWD, 1'b1, '{default: SMAX}, '{out_0: 20'sd262136, default: 0}},
    '{MODE_FWD, 1'b1, '{default: SMIN}, '{out_0: -20'sd262144, default: 0}},
    '{MODE_FWD, 1'b1, '{default: -16'sd1}, '{out_0: -20'sd8, default: 0}},
    '{MODE_FWD, 1'b0, '{SMAX, SMIN, SMAX, SMIN, SMAX, SMIN, SMAX, SMIN}, '{default: 0}},
    '{MODE_FWD, 1'b0, '{SMAX, SMAX, SMAX, SMAX, SMIN, SMIN, SMIN, SMIN}, '{default: 0}},
    '{MODE_FWD, 1'b0, '{in_0: SMAX, default: 0}, '{default: 0}},
    '{MODE_FWD, 1'b0, '{in_7: SMIN, default: 0}, '{default: 0}},
    '{MODE_FWD, 1'b0, '{16'sd1, 16'sd2, 16'sd3, 16'sd4, 16'sd5, 16'sd6, 16'sd7, 16'sd8},
      '{default: 0}},
    '{MODE_FWD, 1'b0, '{in_0: 16'sd1, in_3: -16'sd1, default: 0}, '{default: 0}},
    '{MODE_INV, 1'b1, '{default: 0}, '{default: 0}},
    '{MODE_INV, 1'b1, '{in_0: SMAX, default: 0}, '{default: 20'sd16384}},
    '{MODE_INV, 1'b1, '{in_0: SMIN, default: 0}, '{default: -20'sd16384}},
    '{MODE_INV, 1'b1, '{in_0: 16'sd1, default: 0}, '{default: 20'sd1}},
    '{MODE_INV, 1'b1, '{in_0: -16'sd1, default: 0}, '{default: 0}},
    '{MODE_INV, 1'b0, '{default: SMAX}, '{default: 0}},
    '{MODE_INV, 1'b0, '{default: SMIN}, '{default: 0}},
    '{MODE_INV, 1'b0, '{SMAX, SMIN, SMAX, SMIN, SMAX, SMIN, SMAX, SMIN}, '{default: 0}},
    '{MODE_INV, 1'b0, '{in_1: -16'sd1, default: 0}, '{default: 0}},
    '{MODE_INV, 1'b0, '{in_3: SMAX, in_5: SMIN, default: 0}, '{default: 0}},
    '{MODE_INV, 1'b0, '{in_2: SMAX, in_6: SMIN, in_7: SMAX, in_4: SMIN, default: 0},
      '{default: 0}},
    '{MODE_FWD, 1'b0, '{SMIN, SMAX, SMIN, SMAX, SMIN, SMAX, SMIN, SMAX}, '{default: 0}}
  };

  // Bit-exact transform; right shifts on signed longint are floor shifts.
  function automatic dct8_pkg::out_item_t xform_vector(input dct8_pkg::in_item_t v,
                                                       input bit inv);
    longint d[8];
    longint a0, a1, a2, a3, a4, a5, a6, a7, a8;
    dct8_pkg::out_item_t r;
    for (int k = 0; k < 8; k++) d[k] = $signed(v[(7-k)*SB +: SB]);
    if (!inv) begin
      a0 = d[0]; a1 = d[1]; a2 = d[2]; a3 = d[3];
      a4 = d[4]; a5 = d[5]; a6 = d[6]; a7 = d[7];
      a8 = a7 + a0; a0 = a0 - a7; a7 = a1 + a6; a1 = a1 - a6;
      a6 = a2 + a5; a2 = a2 - a5; a5 = a3 + a4; a3 = a3 - a4;
      a4 = a8 + a5; a8 = a8 - a5; a5 = a7 + a6; a7 = a7 - a6;
      a6 = F_C1 * (a1 + a2);
      a2 = (-F_S1 - F_C1) * a2 + a6;
      a1 = (F_S1 - F_C1) * a1 + a6;
      a6 = F_C3 * (a0 + a3);
      a3 = (-F_S3 - F_C3) * a3 + a6;
      a0 = (F_S3 - F_C3) * a0 + a6;
      a6 = a4 + a5; a4 = a4 - a5;
      a5 = F_R2C6 * (a7 + a8);
      a7 = (-F_R2S6 - F_R2C6) * a7 + a5;
      a8 = (F_R2S6 - F_R2C6) * a8 + a5;
      a5 = a0 + a2; a0 = a0 - a2; a2 = a3 + a1; a3 = a3 - a1;
      d[0] = a6;
      d[4] = a4;
      d[2] = (a8 + 512) >>> 10;
      d[6] = (a7 + 512) >>> 10;
      d[7] = (a2 - a5 + 512) >>> 10;
      d[1] = (a2 + a5 + 512) >>> 10;
      d[3] = (a3 * SQRT2_Q7 + 65536) >>> 17;
      d[5] = (a0 * SQRT2_Q7 + 65536) >>> 17;
    end else begin
      a0 = d[0] * 512; a1 = d[1] * 128; a2 = d[2]; a3 = d[3] * SQRT2_Q7;
      a4 = d[4] * 512; a5 = d[5] * SQRT2_Q7; a6 = d[6]; a7 = d[7] * 128;
      a8 = a7 + a1; a1 = a1 - a7;
      a7 = a0 + a4; a0 = a0 - a4; a4 = a1 + a5; a1 = a1 - a5;
      a5 = a3 + a8; a8 = a8 - a3;
      a3 = I_R2C6 * (a2 + a6);
      a6 = a3 + (-I_R2C6 - I_R2S6) * a6;
      a2 = a3 + (-I_R2C6 + I_R2S6) * a2;
      a3 = a7 + a2; a7 = a7 - a2; a2 = a0 + a6; a0 = a0 - a6;
      a6 = I_C3 * (a4 + a5);
      a5 = (a6 + (-I_C3 - I_S3) * a5) >>> 6;
      a4 = (a6 + (-I_C3 + I_S3) * a4) >>> 6;
      a6 = I_C1 * (a1 + a8);
      a1 = (a6 + (-I_C1 - I_S1) * a1) >>> 6;
      a8 = (a6 + (-I_C1 + I_S1) * a8) >>> 6;
      a7 = a7 + 512; a2 = a2 + 512; a0 = a0 + 512; a3 = a3 + 512;
      d[0] = (a3 + a4) >>> 10;
      d[1] = (a2 + a8) >>> 10;
      d[2] = (a0 + a1) >>> 10;
      d[3] = (a7 + a5) >>> 10;
      d[4] = (a7 - a5) >>> 10;
      d[5] = (a0 - a1) >>> 10;
      d[6] = (a2 - a8) >>> 10;
      d[7] = (a3 - a4) >>> 10;
    end
    r = '0;
    for (int k = 0; k < 8; k++) r[(7-k)*OB +: OB] = d[k][OB-1:0];
    return r;
  endfunction

  function automatic logic signed [SB-1:0] corner_sample();
    case ($urandom_range(0, 6))
      0: return SMAX;
      1: return SMIN;
      2: return '0;
      3: return '1;
      4: return SB'(1);
      5: return SMAX >>> 1;
      default: return SMIN >>> 1;
    endcase
  endfunction

  function automatic dct8_pkg::in_item_t rand_vector();
    dct8_pkg::in_item_t v;
    int base, step, pick;
    v = '0;
    base = int'($urandom_range(0, 32000)) - 16000;
    step = int'($urandom_range(0, 4000)) - 2000;
    pick = $urandom_range(0, 7);
    case ($urandom_range(0, 5))
      0: for (int k = 0; k < 8; k++) v[k*SB +: SB] = SB'($urandom);
      1: for (int k = 0; k < 8; k++) v[k*SB +: SB] = corner_sample();
      2: for (int k = 0; k < 8; k++) v[k*SB +: SB] = SB'(int'($urandom_range(0, 255)) - 128);
      // smooth ramp, like a row of image pixels
      3: for (int k = 0; k < 8; k++) v[(7-k)*SB +: SB] = SB'(base + k * step);
      4: v[pick*SB +: SB] = SB'($urandom);
      default: begin
        for (int k = 0; k < 8; k++)
          v[k*SB +: SB] = $urandom_range(0, 1) ? corner_sample() : SB'($urandom);
      end
    endcase
    return v;
  endfunction

  // Mostly back-to-back, some short gaps, a few long ones, and calm stretches.
  function automatic int unsigned idle_gap();
    int unsigned r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      calm_left = $urandom_range(30, 120);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_vector(input dct8_pkg::in_item_t v, input dct8_pkg::out_item_t want);
    int unsigned gap;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= v;
    do @(posedge clk); while (!in_ready);
    xform_due.push_back(want);
    gap = idle_gap();
    if (gap > 0) begin
      @(negedge clk) in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Mode changes only with the pipeline empty.
  task automatic set_mode(input bit m);
    @(negedge clk) in_valid <= 1'b0;
    while (xform_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(negedge clk) cfg_we <= 1'b0;
    mode_now = m;
  endtask

  initial begin
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_wdata = 1'b0;
    rst_n     = 1'b0;
    mode_now  = MODE_FWD;
    calm_left = 0;
    repeat (7) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // directed part, starting from the reset mode
    foreach (dir_rows[i]) begin
      if (dir_rows[i].inv != mode_now) set_mode(dir_rows[i].inv);
      send_vector(dir_rows[i].stim,
                  dir_rows[i].chk ? dir_rows[i].res
                                  : xform_vector(dir_rows[i].stim, mode_now));
    end
    // explicit write of forward mode as well
    set_mode(MODE_FWD);

    for (int p = 0; p < RAND_PHASES; p++) begin
      set_mode(p % 2 == 0 ? MODE_INV : MODE_FWD);
      for (int n = 0; n < RAND_ITEMS / RAND_PHASES; n++) begin
        dct8_pkg::in_item_t v;
        v = rand_vector();
        send_vector(v, xform_vector(v, mode_now));
      end
    end

    @(negedge clk) in_valid <= 1'b0;
    while (xform_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // result side backpressure
  initial begin
    int unsigned run, stall, r;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      run = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 8);
      r = $urandom_range(0, 99);
      if (r < 55) stall = 0;
      else if (r < 80) stall = $urandom_range(1, 2);
      else if (r < 95) stall = $urandom_range(3, 10);
      else stall = $urandom_range(15, 50);
      @(negedge clk) out_ready <= 1'b1;
      repeat (run - 1) @(negedge clk);
      if (stall > 0) begin
        @(negedge clk) out_ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin : check_result
    dct8_pkg::out_item_t want;
    logic signed [OB-1:0] f_exp, f_got;
    if (rst_n && out_valid && out_ready) begin
      if (xform_due.size() == 0) begin
        $error("result transaction with no input vector pending");
        fail_cnt++;
      end else begin
        want = xform_due.pop_front();
        for (int k = 0; k < 8; k++) begin
          f_exp = want[(7-k)*OB +: OB];
          f_got = out_data[(7-k)*OB +: OB];
          if (f_got !== f_exp) begin
            $error("out_%0d: expected %0d, got %0d", k, f_exp, f_got);
            fail_cnt++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

endmodule

// ----- files.f -----
sv/dct8_pkg.sv
sv/dct8_fwd.sv
sv/dct8_inv.sv
sv/dct8_idct8_fixed_point.sv
sv/dct8_chk.sv
tb/sv/tb.sv
